// ===== rtl/bwm_pkg.sv =====
// ----------------------------------------------------------------------------
// bwm_pkg
// Shared types and constants of the bus window map adaptor.
// ----------------------------------------------------------------------------
package bwm_pkg;

  // Width of one map entry and one halfword latch entry.
  localparam int unsigned ENTRY_W = 16;

  // Default number of narrow window pages backed by the map.
  localparam int unsigned MAP_PAGES_DEF = 16;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] REQ_WIDE_RD   = 2'd0;
  localparam logic [1:0] REQ_WIDE_WR   = 2'd1;
  localparam logic [1:0] REQ_NARROW_RD = 2'd2;
  localparam logic [1:0] REQ_NARROW_WR = 2'd3;

  // Target selector on the output tuser.
  typedef enum logic [3:0] {
    TGT_NONE  = 4'd0,
    TGT_MEM   = 4'd1,
    TGT_DISP  = 4'd2,
    TGT_DCTL  = 4'd3,
    TGT_DISK  = 4'd4,
    TGT_IO    = 4'd5,
    TGT_DIAG  = 4'd6,
    TGT_BUSIF = 4'd7,
    TGT_TAPE  = 4'd8,
    TGT_DREG  = 4'd9
  } tgt_e;

  // Wide bus pages and windows.
  localparam logic [13:0] MEM_LAST_PAGE  = 14'o35773;
  localparam logic [13:0] DEV_PAGE_LO    = 14'o36000;
  localparam logic [13:0] DEV_PAGE_HI    = 14'o36777;
  localparam logic [13:0] NARROW_PAGE_LO = 14'o37000;
  localparam logic [21:0] DISP_BASE      = 22'o17000000;
  localparam logic [21:0] DISP_LAST      = 22'o17077777;
  localparam logic [21:0] DCTL_BASE      = 22'o17377760;
  localparam logic [21:0] DCTL_LAST      = 22'o17377767;
  localparam logic [21:0] DISK_BASE      = 22'o17377774;
  localparam logic [21:0] DISK_LAST      = 22'o17377777;

  // Narrow bus address ranges.
  localparam logic [17:0] WIN_LO    = 18'o140000;
  localparam logic [17:0] WIN_HI    = 18'o177777;
  localparam logic [17:0] MAPREG_LO = 18'o766140;
  localparam logic [17:0] MAPREG_HI = 18'o766176;
  localparam logic [17:0] IO_LO     = 18'o764000;
  localparam logic [17:0] IO_HI     = 18'o764176;
  localparam logic [17:0] DIAG_LO   = 18'o766000;
  localparam logic [17:0] DIAG_HI   = 18'o766036;
  localparam logic [17:0] BUSIF_LO  = 18'o766040;
  localparam logic [17:0] BUSIF_HI  = 18'o766136;
  localparam logic [17:0] TAPE_LO   = 18'o772520;
  localparam logic [17:0] TAPE_HI   = 18'o772532;

  // Map entry layout.
  localparam int unsigned ENT_VALID = 15;
  localparam int unsigned ENT_WEN   = 14;

  // One decoded result.
  typedef struct packed {
    tgt_e        target;
    logic [21:0] offset;
    logic        wr;
    logic [31:0] wdata;
    logic [1:0]  lanes;
    logic [31:0] rdata;
    logic        status;
    logic        wmiss;
    logic        nmiss;
    logic        mfault;
  } res_t;

endpackage

// ===== rtl/bus_window_map_adaptor_top.sv =====
// ----------------------------------------------------------------------------
// bus_window_map_adaptor_top
// Decodes wide-bus and narrow-bus accesses onto targets through a page map.
// ----------------------------------------------------------------------------
// Usage: each input transfer on s_axis carries one access (kind on tuser;
// address, write data, the target's read data and its missing flag on
// tdata). Each access yields exactly one output transfer on m_axis with the
// selected target on tuser and offset, write data, lanes, read data and the
// error flags on tdata.
// The accepting edge loads the decode stage and reads the map and halfword
// latch memories, and the output register takes the access from decode. One
// access is accepted every cycle while the output does not stall; the rate
// is set by the single read port and single write port of each memory, with
// a decode stage write forwarded to a same-page read in the same cycle.
// Reset clears the valid bits of both memories, so every map entry reads as
// invalid and every latch as zero at once; no clearing pass is needed.
// When the receiver stalls, the output register holds its transfer, the
// decode stage keeps one more access, and s_axis_tready then drops.
// ----------------------------------------------------------------------------
module bus_window_map_adaptor_top #(
  parameter int unsigned MAP_PAGES = bwm_pkg::MAP_PAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: address[21:0], write_data[53:22], target_rdata[85:54],
  //        target_missing[86], zero fill[87]
  input  logic [87:0] s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: target_offset[21:0], target_write[22], target_wdata[54:23],
  //        target_lanes[56:55], read_data[88:57], status[89],
  //        wide_missing[90], narrow_missing[91], map_fault[92], zero fill[95:93]
  output logic [95:0] m_axis_tdata,
  // tuser: target[3:0]
  output logic [3:0]  m_axis_tuser
);
  import bwm_pkg::*;

  localparam int unsigned IDX_W = (MAP_PAGES > 1) ? $clog2(MAP_PAGES) : 1;

  // Wide bus decode shared by direct wide accesses and the narrow window.
  function automatic res_t wide_access(input logic [21:0] paddr, input logic wr,
                                       input logic [31:0] wdata,
                                       input logic [31:0] rdata,
                                       input logic missing);
    res_t        r;
    logic [13:0] page;
    logic        hit;
    r    = '0;
    page = paddr[21:8];
    hit  = 1'b1;
    if (page <= MEM_LAST_PAGE) begin
      r.target = TGT_MEM;
      r.offset = paddr;
      r.wmiss  = missing;
    end else if (page >= DEV_PAGE_LO && page <= DEV_PAGE_HI) begin
      if (paddr >= DISP_BASE && paddr <= DISP_LAST) begin
        r.target = TGT_DISP;
        r.offset = paddr - DISP_BASE;
      end else if (paddr >= DCTL_BASE && paddr <= DCTL_LAST) begin
        r.target = TGT_DCTL;
        r.offset = paddr - DCTL_BASE;
      end else if (paddr >= DISK_BASE && paddr <= DISK_LAST) begin
        r.target = TGT_DISK;
        r.offset = paddr - DISK_BASE;
      end else begin
        hit = 1'b0;
      end
    end else begin
      hit = 1'b0;
    end
    if (!hit) begin
      r.status = 1'b1;
      r.wmiss  = 1'b1;
    end else if (wr) begin
      r.wr    = 1'b1;
      r.wdata = wdata;
      r.lanes = 2'd3;
    end else begin
      r.rdata = rdata;
    end
    return r;
  endfunction

  // Input field split.
  logic [21:0] in_addr;
  logic [31:0] in_wdata;
  logic [31:0] in_rdata;
  logic        in_missing;
  assign in_addr    = s_axis_tdata[21:0];
  assign in_wdata   = s_axis_tdata[53:22];
  assign in_rdata   = s_axis_tdata[85:54];
  assign in_missing = s_axis_tdata[86];

  // Handshake and stage control.
  logic accept;
  logic s1_adv;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  // Front decode: enough to address the memories in the accepting cycle.
  logic        in_narrow;
  logic        in_wide;
  logic [17:0] in_uaddr;
  logic        in_win;
  logic [3:0]  in_page;
  logic [6:0]  in_page_ext;
  logic        in_idx_ok;

  always_comb begin
    in_narrow = (s_axis_tuser == REQ_NARROW_RD) || (s_axis_tuser == REQ_NARROW_WR);
    in_wide   = !in_narrow && (in_addr[21:8] < NARROW_PAGE_LO);
    // The narrow window on the wide bus turns a word address into a byte address.
    in_uaddr  = in_narrow ? in_addr[17:0] : {in_addr[16:0], 1'b0};
    in_win    = (in_uaddr >= WIN_LO) && (in_uaddr <= WIN_HI);
    in_page   = in_win ? in_uaddr[13:10] : in_uaddr[4:1];
    in_page_ext = {3'b000, in_page};
    in_idx_ok = in_page_ext < 7'(MAP_PAGES);
  end

  // Decode stage registers.
  logic             s1_wr_q;
  logic             s1_wide_q;
  logic [21:0]      s1_addr_q;
  logic [17:0]      s1_uaddr_q;
  logic [31:0]      s1_wdata_q;
  logic [31:0]      s1_rdata_q;
  logic             s1_missing_q;
  logic             s1_idx_ok_q;
  logic [IDX_W-1:0] s1_idx_q;

  // Memory ports.
  logic [ENTRY_W-1:0] map_rd;
  logic [ENTRY_W-1:0] latch_rd;
  logic               map_we;
  logic               latch_we;
  logic [ENTRY_W-1:0] latch_wd;

  bwm_page_ram #(
    .DEPTH (MAP_PAGES),
    .AW    (IDX_W)
  ) u_map_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_page_ext[IDX_W-1:0]),
    .rd_data_o (map_rd),
    .wr_en_i   (map_we),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (s1_wdata_q[15:0])
  );

  bwm_page_ram #(
    .DEPTH (MAP_PAGES),
    .AW    (IDX_W)
  ) u_latch_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_page_ext[IDX_W-1:0]),
    .rd_data_o (latch_rd),
    .wr_en_i   (latch_we),
    .wr_addr_i (s1_idx_q),
    .wr_data_i (latch_wd)
  );

  // Decode stage: full decode, map lookup and the write-back to the memories.
  res_t               res;
  res_t               res_wide;
  logic               map_we_c;
  logic               latch_we_c;
  logic [ENTRY_W-1:0] entry;
  logic [15:0]        value;
  logic               high;
  logic [21:0]        paddr;
  tgt_e               dev;

  always_comb begin
    res        = '0;
    res_wide   = '0;
    map_we_c   = 1'b0;
    latch_we_c = 1'b0;
    latch_wd   = '0;
    entry      = s1_idx_ok_q ? map_rd : '0;
    value      = s1_wdata_q[15:0];
    high       = s1_uaddr_q[1];
    paddr      = {entry[13:0], s1_uaddr_q[9:2]};
    dev        = TGT_NONE;

    if (s1_wide_q) begin
      res = wide_access(s1_addr_q, s1_wr_q, s1_wdata_q, s1_rdata_q, s1_missing_q);
    end else if (s1_uaddr_q >= WIN_LO && s1_uaddr_q <= WIN_HI) begin
      if (!entry[ENT_VALID] || (s1_wr_q && !entry[ENT_WEN])) begin
        res.mfault = 1'b1;
      end else if (entry[13:0] >= NARROW_PAGE_LO) begin
        // The page maps onto the processor data register.
        res.target = TGT_DREG;
        if (s1_wr_q) begin
          res.wr    = 1'b1;
          res.wdata = high ? {value, 16'h0000} : {16'h0000, value};
          res.lanes = high ? 2'd2 : 2'd1;
        end else begin
          res.rdata = {16'h0000, high ? s1_rdata_q[31:16] : s1_rdata_q[15:0]};
        end
      end else if (s1_wr_q) begin
        if (!high) begin
          latch_we_c = 1'b1;
          latch_wd   = value;
        end else begin
          res = wide_access(paddr, 1'b1, {value, latch_rd}, 32'h0, s1_missing_q);
        end
      end else if (high) begin
        res.rdata = {16'h0000, latch_rd};
      end else begin
        res_wide   = wide_access(paddr, 1'b0, 32'h0, s1_rdata_q, s1_missing_q);
        latch_we_c = 1'b1;
        latch_wd   = res_wide.rdata[31:16];
        res        = res_wide;
        res.rdata  = {16'h0000, res_wide.rdata[15:0]};
      end
    end else if (s1_uaddr_q >= MAPREG_LO && s1_uaddr_q <= MAPREG_HI) begin
      // Map registers themselves; out of range indexes read zero.
      if (s1_idx_ok_q) begin
        if (s1_wr_q) begin
          map_we_c = 1'b1;
        end else begin
          res.rdata = {16'h0000, map_rd};
        end
      end
    end else begin
      if (s1_uaddr_q >= IO_LO && s1_uaddr_q <= IO_HI) begin
        dev = TGT_IO;
      end else if (s1_uaddr_q >= DIAG_LO && s1_uaddr_q <= DIAG_HI) begin
        dev = TGT_DIAG;
      end else if (s1_uaddr_q >= BUSIF_LO && s1_uaddr_q <= BUSIF_HI) begin
        dev = TGT_BUSIF;
      end else if (s1_uaddr_q >= TAPE_LO && s1_uaddr_q <= TAPE_HI) begin
        dev = TGT_TAPE;
      end
      if (dev == TGT_NONE) begin
        res.status = 1'b1;
        res.nmiss  = 1'b1;
      end else begin
        res.target = dev;
        res.offset = {4'h0, s1_uaddr_q};
        if (s1_wr_q) begin
          res.wr    = 1'b1;
          res.wdata = {16'h0000, value};
          res.lanes = 2'd1;
        end else begin
          res.rdata = {16'h0000, s1_rdata_q[15:0]};
        end
      end
    end
  end

  // State changes only once, when the access leaves the decode stage.
  assign map_we   = s1_adv && map_we_c;
  assign latch_we = s1_adv && latch_we_c;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  res_t out_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_wr_q      <= (s_axis_tuser == REQ_WIDE_WR) || (s_axis_tuser == REQ_NARROW_WR);
      s1_wide_q    <= in_wide;
      s1_addr_q    <= in_addr;
      s1_uaddr_q   <= in_uaddr;
      s1_wdata_q   <= in_wdata;
      s1_rdata_q   <= in_rdata;
      s1_missing_q <= in_missing;
      s1_idx_ok_q  <= in_idx_ok;
      s1_idx_q     <= in_page_ext[IDX_W-1:0];
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.target;
  assign m_axis_tdata  = {3'b000, out_q.mfault, out_q.nmiss, out_q.wmiss, out_q.status,
                          out_q.rdata, out_q.lanes, out_q.wdata, out_q.wr,
                          out_q.offset};

endmodule

// ===== rtl/bwm_page_ram.sv =====
// ----------------------------------------------------------------------------
// bwm_page_ram
// Per-page storage with synchronous read, per-entry valid bits so that
// reset reads as zero, and write-to-read forwarding.
// ----------------------------------------------------------------------------
module bwm_page_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [bwm_pkg::ENTRY_W-1:0] rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [bwm_pkg::ENTRY_W-1:0] wr_data_i
);
  import bwm_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  logic [ENTRY_W-1:0] rdata_q;
  logic               rvld_q;
  logic               byp_q;
  logic [ENTRY_W-1:0] byp_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q    <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      byp_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
        // A write landing on the same entry in the read cycle wins.
        byp_q  <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  assign rd_data_o = byp_q  ? byp_data_q :
                     rvld_q ? rdata_q    : '0;

endmodule
